// File: hdl/rsa_crt_modexp_defines.svh
// Assertion macros shared by the RSA CRT engine RTL.
`ifndef RSA_CRT_MODEXP_DEFINES_SVH
`define RSA_CRT_MODEXP_DEFINES_SVH
`ifndef SYNTHESIS
`define RCM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rsa_crt_modexp: assertion failed");
`define RCM_ASSERT_NEVER(lbl, expr) \
	`RCM_ASSERT(lbl, !(expr))
`else
`define RCM_ASSERT(lbl, prop)
`define RCM_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: hdl/rcm_pkg.sv
// Types and constants of the RSA CRT engine.
`timescale 1ns / 1ps
package rcm_pkg;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int RED_STEPS = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIME_P   = 3'd0,
		REG_PRIME_Q   = 3'd1,
		REG_PUB_EXP   = 3'd2,
		REG_EXP_P     = 3'd3,
		REG_EXP_Q     = 3'd4,
		REG_Q_INVERSE = 3'd5
	} reg_idx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_RED = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} mm_req_t;

	typedef enum logic [1:0] {
		PH_N = 2'd0,
		PH_P = 2'd1,
		PH_Q = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE, S_POW_SETUP, S_RED_BASE, S_RED_ONE, S_LOOP, S_MUL_R, S_MUL_SQ,
		S_POW_END, S_RED_M2, S_RED_QI, S_DIFF, S_MUL_H, S_PROD, S_SUM, S_OUT
	} state_t;
endpackage

// File: hdl/rcm_mulmod.sv
// Shared bit-serial modular unit: a*b mod m, or reduction of a 32-bit value mod m.
`timescale 1ns / 1ps
`include "rsa_crt_modexp_defines.svh"
module rcm_mulmod #(
	parameter int MW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rcm_pkg::mm_req_t req,
	input  logic [MW-1:0]    a,
	input  logic [BW-1:0]    b,
	input  logic [MW-1:0]    m,
	output logic             done,
	output logic [MW-1:0]    res
);
	localparam int CW = $clog2(rcm_pkg::RED_STEPS + 1);

	logic          busy_q;
	rcm_pkg::op_t  op_q;
	logic [MW-1:0] acc_q;
	logic [MW-1:0] a_q;
	logic [MW-1:0] m_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          fin;
	logic [MW:0]   t;

	// (x + y) mod m with x, y already below m
	function automatic logic [MW-1:0] addm(input logic [MW-1:0] x, input logic [MW-1:0] y,
		input logic [MW-1:0] md);
		logic [MW:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[MW-1:0];
	endfunction

	assign fin  = busy_q && ((op_q == rcm_pkg::OP_MUL) ? (b_q == '0) : (cnt_q == '0));
	assign done = fin;
	assign res  = (m_q == '0) ? '0 : acc_q;
	// Horner step: 2*acc + next bit, below 2m
	assign t    = {acc_q, b_q[rcm_pkg::RED_STEPS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (fin) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			cnt_q <= CW'(rcm_pkg::RED_STEPS);
		end else if (busy_q && !fin) begin
			if (op_q == rcm_pkg::OP_MUL) begin
				if (b_q[0]) begin
					acc_q <= addm(acc_q, a_q, m_q);
				end
				a_q <= addm(a_q, a_q, m_q);
				b_q <= b_q >> 1;
			end else begin
				acc_q <= (t >= {1'b0, m_q}) ? MW'(t - {1'b0, m_q}) : MW'(t);
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`RCM_ASSERT_NEVER(a_start_while_busy, req.start && busy_q)
	`RCM_ASSERT(a_acc_reduced, busy_q && (m_q != '0) |-> acc_q < m_q)
	`RCM_ASSERT(a_done_frees, done |=> !busy_q)
endmodule

// File: hdl/rsa_crt_modexp.sv
// Top level of the small-key RSA engine with CRT decryption.
`timescale 1ns / 1ps
`include "rsa_crt_modexp_defines.svh"
// One item at a time. An item is a kind on s_tuser (0 encrypt with the public exponent
// mod p*q, 1 decrypt by CRT) and a 32-bit value on s_tdata; it gives one 32-bit beat on
// m_tdata. Reductions and modular multiplies run on one bit-serial modular unit; a modular
// multiply stops once its multiplier has no set bits left. An exponentiation costs two
// reductions plus, per exponent bit up to the top set bit, one squaring and one more
// multiply for each set bit. Decryption splits the work over the two half-size powers,
// mod p and mod q, and then recombines them. s_tready is high only while the engine is
// idle; a finished result waits in the output register without blocking the next item.
module rsa_crt_modexp #(
	parameter int PRIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value_in
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int P  = PRIME_BITS;
	localparam int MW = 2 * PRIME_BITS;
	localparam int BW = (MW > 32) ? MW : 32;

	logic [15:0] prime_p_q, prime_q_q, q_inverse_q;
	logic [31:0] pub_exp_q, exp_p_q, exp_q_q;
	logic [P-1:0] p_w, q_w;
	logic [MW-1:0] n_q;

	rcm_pkg::state_t st_q, st_d;
	rcm_pkg::phase_t phase_q;
	logic          op_busy_q;
	logic [31:0]   v_q;
	logic [MW-1:0] mod_q;
	logic [31:0]   exp_q;
	logic [MW-1:0] base_q, r_q;
	logic [P-1:0]  m1_q, m2_q, m2p_q, qi_q, diff_q, h_q;
	logic [MW-1:0] hq_q;
	logic [31:0]   res_q;
	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic [P:0]    diff_w;

	rcm_pkg::mm_req_t req;
	logic [MW-1:0] opa;
	logic [BW-1:0] opb;
	logic          mm_done;
	logic [MW-1:0] mm_res;
	logic          is_op;

	assign cfg_ready = 1'b1;
	assign p_w = P'(prime_p_q);
	assign q_w = P'(prime_q_q);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign diff_w = (m1_q >= m2p_q) ? {1'b0, m1_q} - {1'b0, m2p_q}
		: {1'b0, m1_q} + {1'b0, p_w} - {1'b0, m2p_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_p_q   <= '0;
			prime_q_q   <= '0;
			pub_exp_q   <= '0;
			exp_p_q     <= '0;
			exp_q_q     <= '0;
			q_inverse_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rcm_pkg::REG_PRIME_P:   prime_p_q   <= cfg_data[15:0];
				rcm_pkg::REG_PRIME_Q:   prime_q_q   <= cfg_data[15:0];
				rcm_pkg::REG_PUB_EXP:   pub_exp_q   <= cfg_data;
				rcm_pkg::REG_EXP_P:     exp_p_q     <= cfg_data;
				rcm_pkg::REG_EXP_Q:     exp_q_q     <= cfg_data;
				rcm_pkg::REG_Q_INVERSE: q_inverse_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// modulus for encryption, kept current from the key registers
	always_ff @(posedge clk) begin
		n_q <= MW'(p_w * q_w);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rcm_pkg::S_IDLE:      if (s_tvalid) st_d = rcm_pkg::S_POW_SETUP;
			rcm_pkg::S_POW_SETUP: st_d = rcm_pkg::S_RED_BASE;
			rcm_pkg::S_RED_BASE:  if (mm_done) st_d = rcm_pkg::S_RED_ONE;
			rcm_pkg::S_RED_ONE:   if (mm_done) st_d = rcm_pkg::S_LOOP;
			rcm_pkg::S_LOOP: begin
				if (exp_q == '0) st_d = rcm_pkg::S_POW_END;
				else if (exp_q[0]) st_d = rcm_pkg::S_MUL_R;
				else st_d = rcm_pkg::S_MUL_SQ;
			end
			rcm_pkg::S_MUL_R:     if (mm_done) st_d = rcm_pkg::S_MUL_SQ;
			rcm_pkg::S_MUL_SQ:    if (mm_done) st_d = rcm_pkg::S_LOOP;
			rcm_pkg::S_POW_END: begin
				unique case (phase_q)
					rcm_pkg::PH_P: st_d = rcm_pkg::S_POW_SETUP;
					rcm_pkg::PH_Q: st_d = rcm_pkg::S_RED_M2;
					default:       st_d = rcm_pkg::S_OUT;
				endcase
			end
			rcm_pkg::S_RED_M2:    if (mm_done) st_d = rcm_pkg::S_RED_QI;
			rcm_pkg::S_RED_QI:    if (mm_done) st_d = rcm_pkg::S_DIFF;
			rcm_pkg::S_DIFF:      st_d = rcm_pkg::S_MUL_H;
			rcm_pkg::S_MUL_H:     if (mm_done) st_d = rcm_pkg::S_PROD;
			rcm_pkg::S_PROD:      st_d = rcm_pkg::S_SUM;
			rcm_pkg::S_SUM:       st_d = rcm_pkg::S_OUT;
			rcm_pkg::S_OUT:       if (!out_valid_q || m_tready) st_d = rcm_pkg::S_IDLE;
			default:              st_d = rcm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == rcm_pkg::S_IDLE);
		is_op    = 1'b0;
		req.op   = rcm_pkg::OP_RED;
		opa      = '0;
		opb      = '0;
		unique case (st_q)
			rcm_pkg::S_RED_BASE: begin
				is_op = 1'b1;
				opb   = BW'(v_q);
			end
			rcm_pkg::S_RED_ONE: begin
				is_op = 1'b1;
				opb   = BW'(1);
			end
			rcm_pkg::S_MUL_R: begin
				is_op  = 1'b1;
				req.op = rcm_pkg::OP_MUL;
				opa    = r_q;
				opb    = BW'(base_q);
			end
			rcm_pkg::S_MUL_SQ: begin
				is_op  = 1'b1;
				req.op = rcm_pkg::OP_MUL;
				opa    = base_q;
				opb    = BW'(base_q);
			end
			rcm_pkg::S_RED_M2: begin
				is_op = 1'b1;
				opb   = BW'(m2_q);
			end
			rcm_pkg::S_RED_QI: begin
				is_op = 1'b1;
				opb   = BW'(q_inverse_q);
			end
			rcm_pkg::S_MUL_H: begin
				is_op  = 1'b1;
				req.op = rcm_pkg::OP_MUL;
				opa    = MW'(qi_q);
				opb    = BW'(diff_q);
			end
			default: ;
		endcase
		req.start = is_op && !op_busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= rcm_pkg::S_IDLE;
			op_busy_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (req.start) begin
				op_busy_q <= 1'b1;
			end else if (mm_done) begin
				op_busy_q <= 1'b0;
			end
			if (st_q == rcm_pkg::S_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			rcm_pkg::S_IDLE: begin
				v_q     <= s_tdata;
				phase_q <= s_tuser ? rcm_pkg::PH_P : rcm_pkg::PH_N;
			end
			rcm_pkg::S_POW_SETUP: begin
				unique case (phase_q)
					rcm_pkg::PH_P: begin
						mod_q <= MW'(p_w);
						exp_q <= exp_p_q;
					end
					rcm_pkg::PH_Q: begin
						mod_q <= MW'(q_w);
						exp_q <= exp_q_q;
					end
					default: begin
						mod_q <= n_q;
						exp_q <= pub_exp_q;
					end
				endcase
			end
			rcm_pkg::S_RED_BASE: if (mm_done) base_q <= mm_res;
			rcm_pkg::S_RED_ONE:  if (mm_done) r_q <= mm_res;
			rcm_pkg::S_MUL_R:    if (mm_done) r_q <= mm_res;
			rcm_pkg::S_MUL_SQ: begin
				if (mm_done) begin
					base_q <= mm_res;
					exp_q  <= exp_q >> 1;
				end
			end
			rcm_pkg::S_POW_END: begin
				unique case (phase_q)
					rcm_pkg::PH_P: begin
						m1_q    <= P'(r_q);
						phase_q <= rcm_pkg::PH_Q;
					end
					rcm_pkg::PH_Q: begin
						m2_q  <= P'(r_q);
						mod_q <= MW'(p_w);
					end
					default: res_q <= 32'(r_q);
				endcase
			end
			rcm_pkg::S_RED_M2: if (mm_done) m2p_q <= P'(mm_res);
			rcm_pkg::S_RED_QI: if (mm_done) qi_q <= P'(mm_res);
			rcm_pkg::S_DIFF:   diff_q <= P'(diff_w);
			rcm_pkg::S_MUL_H:  if (mm_done) h_q <= P'(mm_res);
			rcm_pkg::S_PROD:   hq_q <= MW'(h_q * q_w);
			rcm_pkg::S_SUM:    res_q <= 32'(hq_q + MW'(m2_q));
			rcm_pkg::S_OUT:    if (!out_valid_q || m_tready) out_data_q <= res_q;
			default: ;
		endcase
	end

	rcm_mulmod #(
		.MW(MW),
		.BW(BW)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.a     (opa),
		.b     (opb),
		.m     (mod_q),
		.done  (mm_done),
		.res   (mm_res)
	);

	`RCM_ASSERT(a_done_in_op, mm_done |-> op_busy_q)
	`RCM_ASSERT_NEVER(a_idle_not_busy, (st_q == rcm_pkg::S_IDLE) && op_busy_q)
	`RCM_ASSERT(a_accept_starts, s_tvalid && s_tready |=> st_q == rcm_pkg::S_POW_SETUP)
endmodule

// File: verif/rsa_crt_modexp_test.sv
// Self-checking testbench for the RSA CRT engine: encrypt and CRT decrypt against a predictor.
`timescale 1ns / 1ps
module rsa_crt_modexp_test;
	localparam int PBITS = 16;
	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value_in
	logic        s_tuser;   // [0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] value_out
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	rsa_crt_modexp #(.PRIME_BITS(PBITS)) DUT (.*);

	// key registers held by the predictor
	logic [15:0] key_p, key_q, key_qinv;
	logic [31:0] key_e, key_dp, key_dq;

	logic [31:0] expected_out[$];
	int          error_count;
	int          idle_cycles;
	bit          rx_stall_off;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] prod;
		if (m == 0)
			return '0;
		prod = (a % m) * (b % m);
		return 64'(prod % m);
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] base, logic [31:0] ex, logic [63:0] m);
		logic [63:0] r;
		if (m == 0)
			return '0;
		r = 64'd1 % m;
		base = base % m;
		for (int i = 0; i < 32; i++) begin
			if (ex[i])
				r = mulmod(r, base, m);
			base = mulmod(base, base, m);
		end
		return r;
	endfunction

	function automatic logic [31:0] rsa_result(logic kind, logic [31:0] v);
		logic [63:0] p, q, m1, m2, h, diff, res;
		p = {48'h0, key_p};
		q = {48'h0, key_q};
		if (!kind) begin
			res = powmod({32'h0, v}, key_e, p * q);
			return res[31:0];
		end
		m1 = powmod({32'h0, v}, key_dp, p);
		m2 = powmod({32'h0, v}, key_dq, q);
		h = '0;
		if (p != 0) begin
			diff = (m1 + p - (m2 % p)) % p;
			h = mulmod({48'h0, key_qinv}, diff, p);
		end
		res = m2 + h * q;
		return res[31:0];
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	task automatic random_gap(int hi_short);
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, hi_short);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(rcm_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			rcm_pkg::REG_PRIME_P:   key_p    = val[15:0];
			rcm_pkg::REG_PRIME_Q:   key_q    = val[15:0];
			rcm_pkg::REG_PUB_EXP:   key_e    = val;
			rcm_pkg::REG_EXP_P:     key_dp   = val;
			rcm_pkg::REG_EXP_Q:     key_dq   = val;
			rcm_pkg::REG_Q_INVERSE: key_qinv = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_key(logic [15:0] p, logic [15:0] q, logic [31:0] e,
			logic [31:0] dp, logic [31:0] dq, logic [15:0] qi);
		write_reg(rcm_pkg::REG_PRIME_P, {16'h0, p});
		write_reg(rcm_pkg::REG_PRIME_Q, {16'h0, q});
		write_reg(rcm_pkg::REG_PUB_EXP, e);
		write_reg(rcm_pkg::REG_EXP_P, dp);
		write_reg(rcm_pkg::REG_EXP_Q, dq);
		write_reg(rcm_pkg::REG_Q_INVERSE, {16'h0, qi});
	endtask

	task automatic send_value(logic kind, logic [31:0] v);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		expected_out.push_back(rsa_result(kind, v));
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// engine is idle once every result is out and the output register drains
	task automatic wait_drained();
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_random(int count, bit small_values);
		logic [31:0] v;
		for (int i = 0; i < count; i++) begin
			v = $urandom();
			if (small_values)
				v = v % ((key_p * key_q) + 1);
			send_value(1'($urandom_range(0, 1)), v);
			random_gap(3);
		end
	endtask

	task automatic test_zero_key();
		send_value(1'b0, 32'h0);
		send_value(1'b1, 32'hFFFF_FFFF);
		send_value(1'b0, 32'h1234_5678);
		wait_drained();
	endtask

	task automatic test_textbook_key();
		// p=61 q=53 e=17 d=2753: dP=53 dQ=49 qInv=38
		load_key(16'd61, 16'd53, 32'd17, 32'd53, 32'd49, 16'd38);
		send_value(1'b0, 32'd65);
		send_value(1'b1, 32'd2790);
		send_value(1'b0, 32'd0);
		send_value(1'b1, 32'd0);
		send_value(1'b0, 32'd3232);
		send_value(1'b1, 32'hFFFF_FFFF);
		send_value(1'b0, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_degenerate_moduli();
		// modulus one, zero exponents, q_inverse above p
		load_key(16'd1, 16'd1, 32'd0, 32'd0, 32'd0, 16'hFFFF);
		send_value(1'b0, 32'd5);
		send_value(1'b1, 32'd5);
		wait_drained();
		write_reg(rcm_pkg::REG_PRIME_P, 32'd0);
		write_reg(rcm_pkg::REG_PRIME_Q, 32'd7);
		send_value(1'b1, 32'd123);
		send_value(1'b0, 32'd123);
		wait_drained();
		write_reg(rcm_pkg::REG_PRIME_P, 32'd11);
		write_reg(rcm_pkg::REG_PRIME_Q, 32'd0);
		send_value(1'b1, 32'd99);
		wait_drained();
	endtask

	task automatic test_max_key();
		// largest 16-bit primes, wide result and full exponents
		load_key(16'd65521, 16'd65519, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_value(1'b0, 32'hFFFF_FFFF);
		send_value(1'b1, 32'hFFFF_FFFF);
		send_value(1'b1, 32'h8000_0001);
		wait_drained();
	endtask

	task automatic test_random_keys();
		logic [15:0] p, q;
		for (int k = 0; k < 6; k++) begin
			p = (k < 5) ? 16'($urandom_range(2, 255)) : 16'($urandom());
			q = (k < 5) ? 16'($urandom_range(2, 255)) : 16'($urandom());
			load_key(p, q, $urandom(), $urandom(), $urandom(), 16'($urandom()));
			send_random(k < 5 ? 22 : 8, 1'(k % 2));
			wait_drained();
		end
	endtask

	// results checked in order against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 32'h0);
			end else begin
				if (m_tdata !== expected_out[0])
					report_mismatch("value_out", m_tdata, expected_out[0]);
				void'(expected_out.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (rx_stall_off)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		idle_cycles = 0;
		rx_stall_off = 1'b0;
		{key_p, key_q, key_qinv} = '0;
		{key_e, key_dp, key_dq} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_key();
		test_textbook_key();
		test_degenerate_moduli();
		test_max_key();
		test_random_keys();
		rx_stall_off = 1'b1;
		load_key(16'd13, 16'd17, 32'd5, 32'd5, 32'd13, 16'd10);
		send_random(6, 1'b0);
		wait_drained();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/rcm_pkg.sv
hdl/rcm_mulmod.sv
hdl/rsa_crt_modexp.sv
verif/rsa_crt_modexp_test.sv
